FILE: rtl/can_frame_queue_controller_core_assert.svh
// Assertion macros used by the CAN frame queue controller state machine.
`ifndef CAN_FRAME_QUEUE_CONTROLLER_CORE_ASSERT_SVH
`define CAN_FRAME_QUEUE_CONTROLLER_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
`define CFQC_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("cfqc: assertion failed");
`define CFQC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cfqc: assertion failed");
`else
`define CFQC_ASSERT(lbl, clk, rst_n, prop)
`define CFQC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

FILE: rtl/cfqc_pkg.sv
// Types and constants shared by the CAN frame queue controller modules.
`timescale 1ns / 1ps

package cfqc_pkg;

  localparam int unsigned IN_DATA_W  = 192;
  localparam int unsigned OUT_DATA_W = 184;
  localparam int unsigned KIND_W     = 3;

  typedef logic [KIND_W-1:0] kind_t;

  // Result kinds as carried in the output tuser.
  localparam kind_t KIND_ACCEPTED = 3'd0;
  localparam kind_t KIND_FULL     = 3'd1;
  localparam kind_t KIND_TX_IMAGE = 3'd2;
  localparam kind_t KIND_ERROR    = 3'd3;
  localparam kind_t KIND_RECEIVED = 3'd4;

  // Input mode codes as carried in the input tuser.
  localparam logic MODE_COMMIT    = 1'b0;
  localparam logic MODE_INTERRUPT = 1'b1;

  // Bit positions within the interrupt flag byte.
  localparam int unsigned INT_ERR_BIT = 5;
  localparam int unsigned INT_TXD_BIT = 2;
  localparam int unsigned INT_RX_BIT  = 0;

  // Input word layout, lowest field last.
  typedef struct packed {
    logic [4:0]  pad;
    logic [31:0] timestamp_ms;
    logic [39:0] rx_header;
    logic [7:0]  err_flags;
    logic [7:0]  int_flags;
    logic [63:0] payload;
    logic [3:0]  length;
    logic        remote;
    logic [28:0] identifier;
    logic        ext_flag;
  } item_t;

  // Output word layout, lowest field last.
  typedef struct packed {
    logic [4:0]  pad;
    logic [7:0]  out_err_flags;
    logic [31:0] out_time;
    logic [3:0]  out_length;
    logic        out_remote;
    logic [28:0] out_identifier;
    logic        out_extended;
    logic [63:0] out_payload;
    logic [39:0] tx_header;
  } result_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_commit;
    logic full;
    logic ring_empty;
    logic int_err;
    logic int_txd;
    logic int_rx;
    logic pending;
    logic out_free;
  } status_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic  capture;
    logic  push;
    logic  set_pending;
    logic  clr_pending;
    logic  pop;
    logic  load;
    logic  last;
    kind_t kind;
  } cmd_t;

endpackage

FILE: rtl/cfqc_datapath.sv
// Datapath: input capture, transmit ring, frame packing and unpacking, output register.
`timescale 1ns / 1ps

module cfqc_datapath import cfqc_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [IN_DATA_W-1:0]  s_tdata_i,
  input  logic                  s_tuser_i,
  input  cmd_t                  cmd_i,
  output status_t               status_o,
  output logic                  m_tvalid_o,
  input  logic                  m_tready_i,
  output logic [OUT_DATA_W-1:0] m_tdata_o,
  output kind_t                 m_tuser_o,
  output logic                  m_tlast_o
);

  localparam int unsigned PtrW   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned EntryW = 1 + 29 + 1 + 4 + 64;
  localparam logic [PtrW-1:0] LastSlot = PtrW'(QUEUE_DEPTH - 1);

  function automatic logic [PtrW-1:0] ring_next(input logic [PtrW-1:0] p);
    logic [PtrW-1:0] n;
    n = (p == LastSlot) ? '0 : p + PtrW'(1);
    return n;
  endfunction

  item_t             item_q;
  logic              mode_q;
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic              pending_q, pending_d;
  logic [EntryW-1:0] mem_q [QUEUE_DEPTH];
  logic [EntryW-1:0] rd_entry_q;

  logic              out_valid_q;
  kind_t             out_kind_q;
  logic              out_last_q;
  result_t           out_data_q;
  result_t           res;

  // Head entry fields.
  logic              hd_ext;
  logic [28:0]       hd_id;
  logic              hd_rtr;
  logic [3:0]        hd_len;
  logic [63:0]       hd_data;
  logic [7:0]        tx_sidh, tx_sidl, tx_eidh, tx_eidl, tx_dlc;

  // Received header fields.
  logic [7:0]        rx_sidh, rx_sidl, rx_eidh, rx_eidl, rx_dlc;
  logic              rx_ext, rx_rtr;
  logic [28:0]       rx_id;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      item_q <= item_t'(s_tdata_i);
      mode_q <= s_tuser_i;
    end
  end

  // Ring storage: one write port at the tail, one registered read at the head.
  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      mem_q[wr_ptr_q] <= {item_q.ext_flag, item_q.identifier, item_q.remote,
                          item_q.length, item_q.payload};
    end
    rd_entry_q <= mem_q[rd_ptr_q];
  end

  always_comb begin
    wr_ptr_d  = cmd_i.push ? ring_next(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d  = cmd_i.pop  ? ring_next(rd_ptr_q) : rd_ptr_q;
    pending_d = pending_q;
    if (cmd_i.set_pending) begin
      pending_d = 1'b1;
    end else if (cmd_i.clr_pending) begin
      pending_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q  <= '0;
      rd_ptr_q  <= '0;
      pending_q <= 1'b0;
    end else begin
      wr_ptr_q  <= wr_ptr_d;
      rd_ptr_q  <= rd_ptr_d;
      pending_q <= pending_d;
    end
  end

  assign status_o.is_commit  = (mode_q == MODE_COMMIT);
  assign status_o.full       = (ring_next(wr_ptr_q) == rd_ptr_q);
  assign status_o.ring_empty = (wr_ptr_q == rd_ptr_q);
  assign status_o.int_err    = item_q.int_flags[INT_ERR_BIT];
  assign status_o.int_txd    = item_q.int_flags[INT_TXD_BIT];
  assign status_o.int_rx     = item_q.int_flags[INT_RX_BIT];
  assign status_o.pending    = pending_q;
  assign status_o.out_free   = !out_valid_q || m_tready_i;

  // Controller register image of the head frame.
  always_comb begin
    {hd_ext, hd_id, hd_rtr, hd_len, hd_data} = rd_entry_q;
    if (hd_ext) begin
      tx_sidh = hd_id[28:21];
      tx_sidl = {hd_id[20:18], 1'b0, 1'b1, 1'b0, hd_id[17:16]};
      tx_eidh = hd_id[15:8];
      tx_eidl = hd_id[7:0];
    end else begin
      tx_sidh = hd_id[10:3];
      tx_sidl = {hd_id[2:0], 5'b0};
      tx_eidh = 8'h00;
      tx_eidl = 8'h00;
    end
    tx_dlc = hd_rtr ? 8'h40 : {4'b0, hd_len};
  end

  // Received header unpacked into a message.
  always_comb begin
    {rx_sidh, rx_sidl, rx_eidh, rx_eidl, rx_dlc} = item_q.rx_header;
    rx_ext = rx_sidl[3];
    if (rx_ext) begin
      rx_id  = {rx_sidh, rx_sidl[7:5], rx_sidl[1:0], rx_eidh, rx_eidl};
      rx_rtr = rx_dlc[6];
    end else begin
      rx_id  = {18'b0, rx_sidh, rx_sidl[7:5]};
      rx_rtr = rx_sidl[4];
    end
  end

  always_comb begin
    res = '0;
    unique case (cmd_i.kind)
      KIND_TX_IMAGE: begin
        res.tx_header   = {tx_sidh, tx_sidl, tx_eidh, tx_eidl, tx_dlc};
        res.out_payload = hd_rtr ? 64'd0 : hd_data;
      end
      KIND_ERROR: begin
        res.out_time      = item_q.timestamp_ms;
        res.out_err_flags = item_q.err_flags;
      end
      KIND_RECEIVED: begin
        res.out_payload    = rx_rtr ? 64'd0 : item_q.payload;
        res.out_extended   = rx_ext;
        res.out_identifier = rx_id;
        res.out_remote     = rx_rtr;
        res.out_length     = rx_rtr ? 4'd0 : rx_dlc[3:0];
        res.out_time       = item_q.timestamp_ms;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load) begin
      out_valid_q <= 1'b1;
    end else if (m_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      out_data_q <= res;
      out_kind_q <= cmd_i.kind;
      out_last_q <= cmd_i.last;
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = out_data_q;
  assign m_tuser_o  = out_kind_q;
  assign m_tlast_o  = out_last_q;

endmodule

FILE: rtl/cfqc_ctrl.sv
// Controller state machine: sequences capture, decode, queue read and result loading.
`timescale 1ns / 1ps
`include "can_frame_queue_controller_core_assert.svh"

module cfqc_ctrl import cfqc_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    s_tvalid_i,
  output logic    s_tready_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_READ = 2'd2;
  localparam logic [1:0] ST_SEND = 2'd3;

  logic [1:0] state_q, state_d;

  assign s_tready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.kind = KIND_ACCEPTED;
    unique case (state_q)
      ST_IDLE: begin
        if (s_tvalid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (status_i.is_commit) begin
          if (status_i.out_free) begin
            cmd_o.load = 1'b1;
            if (status_i.full) begin
              cmd_o.kind = KIND_FULL;
              cmd_o.last = 1'b1;
              state_d    = ST_IDLE;
            end else begin
              cmd_o.push = 1'b1;
              cmd_o.kind = KIND_ACCEPTED;
              cmd_o.last = status_i.pending;
              if (status_i.pending) begin
                state_d = ST_IDLE;
              end else begin
                cmd_o.set_pending = 1'b1;
                state_d           = ST_READ;
              end
            end
          end
        end else if (status_i.int_err) begin
          if (status_i.out_free) begin
            cmd_o.load = 1'b1;
            cmd_o.kind = KIND_ERROR;
            cmd_o.last = 1'b1;
            state_d    = ST_IDLE;
          end
        end else if (status_i.int_txd) begin
          if (status_i.ring_empty) begin
            cmd_o.clr_pending = 1'b1;
            state_d           = ST_IDLE;
          end else begin
            cmd_o.set_pending = 1'b1;
            state_d           = ST_READ;
          end
        end else if (status_i.int_rx) begin
          if (status_i.out_free) begin
            cmd_o.load = 1'b1;
            cmd_o.kind = KIND_RECEIVED;
            cmd_o.last = 1'b1;
            state_d    = ST_IDLE;
          end
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_READ: begin
        // The head entry is re-read here so that a frame written during decode is seen.
        state_d = ST_SEND;
      end
      ST_SEND: begin
        if (status_i.out_free) begin
          cmd_o.load = 1'b1;
          cmd_o.pop  = 1'b1;
          cmd_o.kind = KIND_TX_IMAGE;
          cmd_o.last = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `CFQC_ASSERT(a_load_needs_room, clk_i, rst_ni, cmd_o.load |-> status_i.out_free)
  `CFQC_ASSERT(a_no_push_when_full, clk_i, rst_ni, cmd_o.push |-> !status_i.full)
  `CFQC_ASSERT(a_no_pop_when_empty, clk_i, rst_ni, cmd_o.pop |-> !status_i.ring_empty)
  `CFQC_ASSERT_NEXT(a_capture_leaves_idle, clk_i, rst_ni, cmd_o.capture, state_q != ST_IDLE)

endmodule

FILE: rtl/can_frame_queue_controller_core.sv
// Top level of the CAN frame queue controller: transmit ring and interrupt decoder.
`timescale 1ns / 1ps

// The block takes one input word at a time. An input word marked as a commit (tuser low)
// queues a frame in a transmit ring of QUEUE_DEPTH entries, which holds at most
// QUEUE_DEPTH-1 frames; a full ring refuses the frame with a single result word. When no
// transmission is in flight, the accepted frame is packed at once into a controller
// register image (sidh, sidl, eidh, eidl, dlc) and follows the acceptance word. An input
// word marked as an interrupt (tuser high) is decoded with priority error, then
// transmit-done, then receive: error gives a timestamped error report, transmit-done
// sends the next queued frame or clears the pending flag without a result, and receive
// unpacks the raw header into a message. Remote frames carry zero length and payload.
// The result kind travels in m_axis_tuser and tlast marks the final result word of each
// input word. Timing: an input word is taken in the idle state and decoded in the next
// cycle. A word that sends a transmit image then passes through the read and send states,
// because the ring is a memory with a registered read port at the head pointer: the head
// entry is read in the read state and the image is loaded in the send state. The output
// register parts the two sides: a new word is accepted while a finished result still
// waits, and decode only stalls when it has a result to load and the output register is
// still occupied. There is no clearing pass after reset.

module can_frame_queue_controller_core import cfqc_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // s_axis_tdata fields, lowest bit up: ext_flag(1), identifier(29), remote(1),
  // length(4), payload(64), int_flags(8), err_flags(8), rx_header(40),
  // timestamp_ms(32), zero fill(5).
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // s_axis_tuser fields: mode(1).
  input  logic                  s_axis_tuser,
  // m_axis_tdata fields, lowest bit up: tx_header(40), out_payload(64),
  // out_extended(1), out_identifier(29), out_remote(1), out_length(4),
  // out_time(32), out_err_flags(8), zero fill(5).
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // m_axis_tuser fields: kind(3).
  output logic [KIND_W-1:0]     m_axis_tuser,
  output logic                  m_axis_tlast
);

  cmd_t    cmd;
  status_t status;

  // The controller owns the sequencing; the datapath owns every stored frame and pointer.
  cfqc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  cfqc_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tdata_i  (s_axis_tdata),
    .s_tuser_i  (s_axis_tuser),
    .cmd_i      (cmd),
    .status_o   (status),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .m_tdata_o  (m_axis_tdata),
    .m_tuser_o  (m_axis_tuser),
    .m_tlast_o  (m_axis_tlast)
  );

endmodule

FILE: tb/cfqc_frame_checker.sv
// Checker for the CAN frame queue controller: predicts every result word and compares it.
`timescale 1ns / 1ps

module cfqc_frame_checker import cfqc_pkg::*; #(
  parameter int unsigned DEPTH = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_valid_i,
  input  logic                  s_ready_i,
  input  logic [IN_DATA_W-1:0]  s_data_i,
  input  logic                  s_mode_i,
  input  logic                  m_valid_i,
  input  logic                  m_ready_i,
  input  logic [OUT_DATA_W-1:0] m_data_i,
  input  logic [KIND_W-1:0]     m_kind_i,
  input  logic                  m_last_i,
  output int                    fail_count_o,
  output int                    outstanding_o
);

  // Bit positions inside the controller identifier and length registers.
  localparam int unsigned SIDL_EXT_BIT = 3;
  localparam int unsigned SIDL_SRR_BIT = 4;
  localparam int unsigned DLC_RTR_BIT  = 6;
  localparam logic [7:0]  DLC_REMOTE   = 8'h40;
  localparam int unsigned REPORT_MAX   = 10;

  typedef struct packed {
    logic        ext;
    logic [28:0] id;
    logic        rtr;
    logic [3:0]  len;
    logic [63:0] data;
  } frame_t;

  typedef struct packed {
    kind_t   kind;
    logic    last;
    result_t word;
  } outcome_t;

  frame_t      tx_ring [DEPTH];
  int unsigned head_idx;
  int unsigned tail_idx;
  logic        in_flight;
  outcome_t    due_q[$];

  initial fail_count_o = 0;
  initial outstanding_o = 0;

  function automatic int unsigned ring_step(int unsigned p);
    return (p + 1) % DEPTH;
  endfunction

  // Register image of a frame as the host writes it to the transmit buffer.
  function automatic outcome_t tx_image(frame_t f);
    outcome_t   o;
    logic [7:0] sidh, sidl, eidh, eidl, dlc;
    o = '0;
    if (f.ext) begin
      sidh = f.id[28:21];
      // Identifier bits 20..18 on top, the extended-frame flag in bit 3, bits 17..16 at the bottom.
      sidl = {f.id[20:18], 1'b0, 1'b1, 1'b0, f.id[17:16]};
      eidh = f.id[15:8];
      eidl = f.id[7:0];
    end else begin
      sidh = f.id[10:3];
      sidl = {f.id[2:0], 5'd0};
      eidh = 8'd0;
      eidl = 8'd0;
    end
    dlc = f.rtr ? DLC_REMOTE : {4'd0, f.len};
    o.kind = KIND_TX_IMAGE;
    o.last = 1'b1;
    o.word.tx_header = {sidh, sidl, eidh, eidl, dlc};
    o.word.out_payload = f.rtr ? 64'd0 : f.data;
    return o;
  endfunction

  function automatic outcome_t rx_message(item_t it);
    outcome_t    o;
    logic [7:0]  sidh, sidl, eidh, eidl, dlc;
    logic        rtr;
    o = '0;
    {sidh, sidl, eidh, eidl, dlc} = it.rx_header;
    o.word.out_extended = sidl[SIDL_EXT_BIT];
    if (sidl[SIDL_EXT_BIT]) begin
      o.word.out_identifier = {sidh, sidl[7:5], sidl[1:0], eidh, eidl};
      rtr = dlc[DLC_RTR_BIT];
    end else begin
      o.word.out_identifier = {18'd0, sidh, sidl[7:5]};
      rtr = sidl[SIDL_SRR_BIT];
    end
    o.kind = KIND_RECEIVED;
    o.last = 1'b1;
    o.word.out_remote = rtr;
    o.word.out_length = rtr ? 4'd0 : dlc[3:0];
    o.word.out_payload = rtr ? 64'd0 : it.payload;
    o.word.out_time = it.timestamp_ms;
    return o;
  endfunction

  task automatic launch_head();
    due_q.push_back(tx_image(tx_ring[head_idx]));
    head_idx = ring_step(head_idx);
  endtask

  task automatic predict_word(logic mode, item_t it);
    outcome_t o;
    frame_t   f;
    o = '0;
    o.last = 1'b1;
    if (mode == MODE_COMMIT) begin
      if (ring_step(tail_idx) == head_idx) begin
        o.kind = KIND_FULL;
        due_q.push_back(o);
      end else begin
        f.ext = it.ext_flag;
        f.id = it.identifier;
        f.rtr = it.remote;
        f.len = it.length;
        f.data = it.payload;
        tx_ring[tail_idx] = f;
        tail_idx = ring_step(tail_idx);
        o.kind = KIND_ACCEPTED;
        o.last = in_flight;
        due_q.push_back(o);
        if (!in_flight) begin
          in_flight = 1'b1;
          launch_head();
        end
      end
    end else if (it.int_flags[INT_ERR_BIT]) begin
      o.kind = KIND_ERROR;
      o.word.out_time = it.timestamp_ms;
      o.word.out_err_flags = it.err_flags;
      due_q.push_back(o);
    end else if (it.int_flags[INT_TXD_BIT]) begin
      if (head_idx != tail_idx) begin
        in_flight = 1'b1;
        launch_head();
      end else begin
        in_flight = 1'b0;
      end
    end else if (it.int_flags[INT_RX_BIT]) begin
      due_q.push_back(rx_message(it));
    end
  endtask

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      if (fail_count_o < REPORT_MAX)
        $display("cfqc check: %s expected %h got %h", name, want, got);
      fail_count_o++;
    end
  endtask

  task automatic compare_word(kind_t kind, logic last, result_t got);
    outcome_t o;
    if (due_q.size() == 0) begin
      if (fail_count_o < REPORT_MAX)
        $display("cfqc check: result word of kind %0d with nothing expected", kind);
      fail_count_o++;
    end else begin
      o = due_q.pop_front();
      check_field("kind", 64'(o.kind), 64'(kind));
      check_field("last", 64'(o.last), 64'(last));
      check_field("tx_header", 64'(o.word.tx_header), 64'(got.tx_header));
      check_field("out_payload", o.word.out_payload, got.out_payload);
      check_field("out_extended", 64'(o.word.out_extended), 64'(got.out_extended));
      check_field("out_identifier", 64'(o.word.out_identifier),
                  64'(got.out_identifier));
      check_field("out_remote", 64'(o.word.out_remote), 64'(got.out_remote));
      check_field("out_length", 64'(o.word.out_length), 64'(got.out_length));
      check_field("out_time", 64'(o.word.out_time), 64'(got.out_time));
      check_field("out_err_flags", 64'(o.word.out_err_flags), 64'(got.out_err_flags));
    end
  endtask

  // Input words are predicted before output words are compared; a word taken at this
  // edge can never produce a result at the same edge, so the order is only for safety.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_idx = 0;
      tail_idx = 0;
      in_flight = 1'b0;
      due_q.delete();
    end else begin
      if (s_valid_i && s_ready_i) predict_word(s_mode_i, item_t'(s_data_i));
      if (m_valid_i && m_ready_i) compare_word(m_kind_i, m_last_i, result_t'(m_data_i));
    end
    outstanding_o = due_q.size();
  end

endmodule

FILE: tb/tb_top.sv
// Testbench top for the CAN frame queue controller: stimulus, handshake idling and verdict.
`timescale 1ns / 1ps

module tb_top;
  import cfqc_pkg::*;

  localparam int unsigned DEPTH        = 8;
  localparam int unsigned RANDOM_WORDS = 700;
  // The final stretch of words runs with both sides always ready.
  localparam int unsigned CALM_TAIL    = 100;
  // A word's passage through the block and every idle stretch on either side are bounded,
  // so reaching this limit with no word moving on either side is taken as a hang.
  localparam int unsigned QUIET_LIMIT  = 4000;
  localparam int unsigned SETTLE       = 16;

  // Classes of interrupt word, chosen by the flag bits that win the priority decode.
  typedef enum logic [1:0] {
    IRQ_ERROR,
    IRQ_TXDONE,
    IRQ_RECEIVE,
    IRQ_NONE
  } irq_class_e;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  item_t                 s_tdata = '0;
  logic                  s_tuser = MODE_COMMIT;
  logic                  m_tvalid;
  logic                  m_tready = 1'b1;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [KIND_W-1:0]     m_tuser;
  logic                  m_tlast;

  int          fail_count;
  int          outstanding;
  bit          idle_on = 1'b1;
  int unsigned stall_left = 0;
  int unsigned quiet_cycles = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  can_frame_queue_controller_core #(
    .QUEUE_DEPTH(DEPTH)
  ) dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .s_axis_tvalid(s_tvalid),
    .s_axis_tready(s_tready),
    .s_axis_tdata (s_tdata),
    .s_axis_tuser (s_tuser),
    .m_axis_tvalid(m_tvalid),
    .m_axis_tready(m_tready),
    .m_axis_tdata (m_tdata),
    .m_axis_tuser (m_tuser),
    .m_axis_tlast (m_tlast)
  );

  cfqc_frame_checker #(
    .DEPTH(DEPTH)
  ) u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .s_valid_i    (s_tvalid),
    .s_ready_i    (s_tready),
    .s_data_i     (s_tdata),
    .s_mode_i     (s_tuser),
    .m_valid_i    (m_tvalid),
    .m_ready_i    (m_tready),
    .m_data_i     (m_tdata),
    .m_kind_i     (m_tuser),
    .m_last_i     (m_tlast),
    .fail_count_o (fail_count),
    .outstanding_o(outstanding)
  );

  // The result side stalls in random bursts while idling is enabled.
  // The burst counter belongs to this process alone.
  always @(negedge clk) begin
    if (stall_left == 0 && idle_on && $urandom_range(9, 0) == 0)
      stall_left = $urandom_range(19, 1);
    if (stall_left != 0) begin
      m_tready <= 1'b0;
      stall_left--;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Watchdog: counts cycles in which no word moves on either side.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("tb_top: done, errors");
          $finish;
        end
      end
    end
  end

  // Every field random, so that fields the block ignores for a given mode still toggle.
  function automatic item_t noise_item();
    item_t it;
    it = '0;
    it.ext_flag = 1'($urandom);
    it.identifier = 29'($urandom);
    it.remote = 1'($urandom);
    it.length = 4'($urandom);
    it.payload = {32'($urandom), 32'($urandom)};
    it.int_flags = 8'($urandom);
    it.err_flags = 8'($urandom);
    it.rx_header = {8'($urandom), 32'($urandom)};
    it.timestamp_ms = 32'($urandom);
    return it;
  endfunction

  function automatic logic [7:0] irq_flags(irq_class_e cls);
    logic [7:0] f;
    f = 8'($urandom);
    f[INT_ERR_BIT] = (cls == IRQ_ERROR);
    if (cls != IRQ_ERROR) f[INT_TXD_BIT] = (cls == IRQ_TXDONE);
    if (cls == IRQ_RECEIVE || cls == IRQ_NONE) f[INT_RX_BIT] = (cls == IRQ_RECEIVE);
    return f;
  endfunction

  // Presents one word from the falling edge and holds it until the rising edge that takes
  // it. A gap, when drawn, lowers tvalid at the first falling edge and raises it again
  // only at a later one, so tvalid never sees two assignments in one time step.
  task automatic send_word(logic mode, item_t it);
    int unsigned gap;
    gap = (idle_on && $urandom_range(4, 0) == 0) ? $urandom_range(19, 1) : 0;
    @(negedge clk);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= it;
    s_tuser <= mode;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic commit_frame(logic ext, logic [28:0] id, logic rtr, logic [3:0] len,
                              logic [63:0] data);
    item_t it;
    it = noise_item();
    it.ext_flag = ext;
    it.identifier = id;
    it.remote = rtr;
    it.length = len;
    it.payload = data;
    send_word(MODE_COMMIT, it);
  endtask

  task automatic raise_irq(logic [7:0] flags, logic [7:0] errs, logic [39:0] hdr,
                           logic [31:0] stamp);
    item_t it;
    it = noise_item();
    it.int_flags = flags;
    it.err_flags = errs;
    it.rx_header = hdr;
    it.timestamp_ms = stamp;
    send_word(MODE_INTERRUPT, it);
  endtask

  task automatic random_commit();
    commit_frame(1'($urandom), 29'($urandom), $urandom_range(3, 0) == 0, 4'($urandom),
                 {32'($urandom), 32'($urandom)});
  endtask

  initial begin
    irq_class_e  cls;
    int unsigned commit_pct;
    int unsigned pick;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part. Interrupt words whose flags decode to nothing, and a transmit-done
    // while the ring is empty, must produce no word at all.
    raise_irq(8'h00, 8'h00, 40'd0, 32'd0);
    raise_irq(8'hDA, 8'hFF, {8'($urandom), 32'($urandom)}, 32'($urandom));
    raise_irq(8'h04, 8'($urandom), {8'($urandom), 32'($urandom)}, 32'($urandom));
    // Standard frame with every identifier bit set: only the low eleven bits may show.
    commit_frame(1'b0, 29'h1FFF_FFFF, 1'b0, 4'hF, 64'hFFFF_FFFF_FFFF_FFFF);
    // Extended remote frame, queued behind the one in flight.
    commit_frame(1'b1, 29'h1FFF_FFFF, 1'b1, 4'h8, {32'($urandom), 32'($urandom)});
    commit_frame(1'b1, 29'd0, 1'b0, 4'h0, 64'd0);
    // Five more fill the ring to its capacity of DEPTH-1 frames; the next is refused.
    repeat (5) random_commit();
    commit_frame(1'b0, 29'd0, 1'b0, 4'h1, 64'd1);
    // Error wins over every other flag.
    raise_irq(8'hFF, 8'hFF, 40'hFF_FFFF_FFFF, 32'hFFFF_FFFF);
    // Transmit-done wins over receive and sends the remote frame.
    raise_irq(8'h07, 8'h00, {8'($urandom), 32'($urandom)}, 32'($urandom));
    // Received standard remote, extended remote, extended data and standard data frames.
    raise_irq(8'h01, 8'h00, 40'hFF_F7_FF_FF_FF, 32'($urandom));
    raise_irq(8'h01, 8'h00, 40'hFF_FF_FF_FF_FF, 32'($urandom));
    raise_irq(8'hC3, 8'h00, 40'hFF_EB_12_34_0F, 32'($urandom));
    raise_irq(8'h01, 8'h00, 40'd0, 32'd0);
    // Drain the six frames left, then one more transmit-done clears the in-flight flag.
    repeat (7) raise_irq(8'h04, 8'($urandom), {8'($urandom), 32'($urandom)}, 32'($urandom));

    // Random part. Phases alternate between commit-heavy, which keeps the ring near full,
    // and transmit-done-heavy, which drains it; idling is switched off in some stretches.
    commit_pct = 60;
    for (int unsigned i = 0; i < RANDOM_WORDS; i++) begin
      if (i % 60 == 0) commit_pct = (commit_pct == 60) ? 30 : 60;
      idle_on = (i < RANDOM_WORDS - CALM_TAIL) && ((i / 90) % 4 != 3);
      if ($urandom_range(99, 0) < commit_pct) begin
        random_commit();
      end else begin
        pick = $urandom_range(9, 0);
        cls = (pick < 2) ? IRQ_ERROR : (pick < 7) ? IRQ_TXDONE :
              (pick < 9) ? IRQ_RECEIVE : IRQ_NONE;
        raise_irq(irq_flags(cls), 8'($urandom), {8'($urandom), 32'($urandom)},
                  32'($urandom));
      end
    end

    @(negedge clk);
    s_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
